@@ src/ptvm_pkg.sv @@
// Shared types, constants and table builders for the tone voice mixer.
package ptvm_pkg;

  localparam int MAX_VOICES      = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int PAN_TABLE_BITS  = 8;

  localparam int SLOT_W    = $clog2(MAX_VOICES);
  localparam int VCNT_W    = $clog2(MAX_VOICES + 1);
  localparam int SINE_SIZE = (1 << SINE_TABLE_BITS) + 1;
  localparam int PAN_SIZE  = (1 << PAN_TABLE_BITS) + 1;
  localparam int SIDX_W    = SINE_TABLE_BITS + 1;
  localparam int PIDX_W    = PAN_TABLE_BITS + 1;
  localparam int KT_W      = 17 + PAN_TABLE_BITS;
  localparam int GAIN_W    = 15;
  localparam int ACC_W     = 48 + SLOT_W;
  localparam int PROD_W    = ACC_W + GAIN_W;
  localparam int IT_W      = $clog2(ACC_W + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [31:0] PHASE_SCALE_RST  = 32'd89478;
  localparam logic [15:0] ATTACK_STEP_RST  = 16'd273;
  localparam logic [15:0] RELEASE_STEP_RST = 16'd23;
  localparam logic [14:0] OUTPUT_GAIN_RST  = 15'd32767;
  localparam logic [63:0] HALF_PI_Q30      = 64'd1686629713;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_NOTE_ON = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_ALL_OFF = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_SCALE  = 3'd0,
    CFG_ATTACK_STEP  = 3'd1,
    CFG_RELEASE_STEP = 3'd2,
    CFG_OUTPUT_GAIN  = 3'd3,
    CFG_ENGINE_RUN   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [6:0]  note;
    logic [7:0]  instrument;
    logic [31:0] phase;
    logic [31:0] step;
    logic [15:0] level;
    logic [15:0] target;
    logic [15:0] pan;
    logic        releasing;
  } slot_t;

  typedef logic [14:0] sine_rom_t [SINE_SIZE];
  typedef logic [15:0] pan_rom_t [PAN_SIZE];

  // Quarter sine from a truncating Taylor series in Q2.30.
  function automatic sine_rom_t build_sine();
    sine_rom_t          t;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    for (int i = 0; i < SINE_SIZE; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 64'sd0;
      v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      t[i] = (v > 64'd32767) ? 15'd32767 : 15'(v);
    end
    return t;
  endfunction

  function automatic logic [15:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = 64'd0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return 16'(res);
  endfunction

  function automatic pan_rom_t build_pan();
    pan_rom_t t;
    for (int k = 0; k < PAN_SIZE; k++) begin
      t[k] = isqrt64(64'(k) << (30 - PAN_TABLE_BITS));
    end
    return t;
  endfunction

endpackage

@@ src/ptvm_cfg_if.sv @@
// Configuration write channel.
interface ptvm_cfg_if import ptvm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/ptvm_in_if.sv @@
// Input item channel.
interface ptvm_in_if import ptvm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [6:0]  note;
  logic [7:0]  instrument;
  logic [23:0] freq_hz;
  logic [15:0] velocity;
  logic        retrigger;
  logic [15:0] pan;

  modport source (output valid, output op, output note, output instrument, output freq_hz,
                  output velocity, output retrigger, output pan, input ready);
  modport sink (input valid, input op, input note, input instrument, input freq_hz,
                input velocity, input retrigger, input pan, output ready);
endinterface

@@ src/ptvm_out_if.sv @@
// Result item channel.
interface ptvm_out_if import ptvm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [4:0]        active_voices;
  logic [1:0]        status;

  modport source (output valid, output left_sample, output right_sample,
                  output active_voices, output status, input ready);
  modport sink (input valid, input left_sample, input right_sample,
                input active_voices, input status, output ready);
endinterface

@@ src/ptvm_div.sv @@
// Restoring divider, one quotient bit per cycle, for the mix magnitude over the voice count.
module ptvm_div import ptvm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ACC_W-1:0]  dividend_i,
  input  logic [VCNT_W-1:0] divisor_i,
  output logic              done_o,
  output logic [ACC_W-1:0]  quotient_o
);

  logic              busy_q;
  logic              done_q;
  logic [IT_W-1:0]   it_q;
  logic [VCNT_W-1:0] rem_q;
  logic [ACC_W-1:0]  dvd_q;
  logic [VCNT_W:0]   trial;
  logic [VCNT_W:0]   diff;
  logic              ge;

  assign trial = {rem_q, dvd_q[ACC_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      it_q   <= IT_W'(ACC_W);
    end else if (busy_q) begin
      it_q <= it_q - IT_W'(1);
      if (it_q == IT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[VCNT_W-1:0] : trial[VCNT_W-1:0];
      dvd_q <= {dvd_q[ACC_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

@@ src/polyphonic_tone_voice_mixer.sv @@
// Polyphonic tone voice mixer: voice table, sine/pan tables and stereo mix.
//
// Channels: cfg_i writes one register per transfer (index, data) and is always
// ready. in_i takes one item per transfer (tick, note on, note off, all off);
// out_o returns exactly one result per item, in order.
// The voice state sits in one slot memory with a registered read. Every item
// other than an ignored note on sweeps the slots, one per cycle: a read, then,
// for a tick, note off or all off, a write back of the modified slot. A tick
// then runs a five-stage pipeline (memory read, sine and pan table read, level
// multiply, pan multiply, accumulate) and a one-bit-per-cycle divide by the
// voice count. The next item is taken in the cycle after its predecessor's
// result is posted.
// One item is in flight at a time; in_i.ready is high while no item is at work.
// A finished result waits in the output register while the next item is taken;
// a stalled receiver holds the block only when a second result is ready.
// Reset clears all voices and restores the register defaults; no clearing pass.
module polyphonic_tone_voice_mixer import ptvm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptvm_cfg_if.sink   cfg_i,
  ptvm_in_if.sink    in_i,
  ptvm_out_if.source out_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SWEEP, ST_DRAIN, ST_ALLOC, ST_DIV, ST_MUL, ST_RND, ST_DONE
  } state_e;

  localparam sine_rom_t SINE_ROM = build_sine();
  localparam pan_rom_t  PAN_ROM  = build_pan();

  // configuration
  logic [31:0]       phase_scale_q;
  logic [15:0]       attack_q;
  logic [15:0]       release_q;
  logic [GAIN_W-1:0] gain_q;
  logic              engine_q;

  state_e            state_q;
  logic [SLOT_W-1:0] sweep_q;
  logic [MAX_VOICES-1:0] valid_q;
  logic [VCNT_W-1:0] cnt_q;
  logic [VCNT_W-1:0] n_q;

  op_e         op_q;
  logic [6:0]  note_q;
  logic [7:0]  ins_q;
  logic [15:0] vel_q;
  logic        retrig_q;
  logic [15:0] pan_q;
  logic [31:0] step_q;

  logic              hit_q;
  logic [SLOT_W-1:0] hit_idx_q;
  slot_t             hit_word_q;
  logic              free_q;
  logic [SLOT_W-1:0] free_idx_q;

  slot_t mem [MAX_VOICES];
  slot_t rd_q;

  // pipeline
  logic              a_vld_q;
  logic [SLOT_W-1:0] a_slot_q;
  logic              c_vld_q;
  logic [14:0]       sine_q;
  logic              sneg_q;
  logic [15:0]       lvl_c_q;
  logic [15:0]       gr_c_q;
  logic [15:0]       gl_c_q;
  logic              d_vld_q;
  logic signed [31:0] vs_q;
  logic [15:0]       gr_q;
  logic [15:0]       gl_q;
  logic              e_vld_q;
  logic signed [48:0] pr_q;
  logic signed [48:0] pl_q;
  logic signed [ACC_W-1:0] acc_l_q;
  logic signed [ACC_W-1:0] acc_r_q;

  logic              negl_q;
  logic              negr_q;
  logic [PROD_W-1:0] prod_l_q;
  logic [PROD_W-1:0] prod_r_q;

  logic [15:0] res_l_q;
  logic [15:0] res_r_q;
  status_e     stat_q;

  logic        out_valid_q;
  logic [15:0] out_l_q;
  logic [15:0] out_r_q;
  logic [4:0]  out_cnt_q;
  status_e     out_stat_q;

  // combinational
  logic              in_xfer;
  logic              issue;
  logic              pipe_empty;
  logic              b_slot_vld;
  logic              b_match;
  logic [31:0]       ph_new;
  logic [16:0]       lvl_up;
  logic [15:0]       lvl_new;
  logic [SINE_TABLE_BITS-1:0] sfrac;
  logic [SIDX_W-1:0] sidx;
  logic [KT_W-1:0]   ktmp;
  logic [PIDX_W-1:0] kr;
  logic [PIDX_W-1:0] kl;
  logic              b_free;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  slot_t             mem_wdata;
  logic [23:0]       f_min;
  logic [55:0]       step_prod;
  logic [30:0]       vmag;
  logic signed [31:0] vs_d;
  logic [ACC_W-1:0]  mag_l;
  logic [ACC_W-1:0]  mag_r;
  logic              div_start;
  logic              done_l;
  logic              done_r;
  logic [ACC_W-1:0]  quo_l;
  logic [ACC_W-1:0]  quo_r;

  function automatic logic [15:0] round_sat(input logic [PROD_W-1:0] p, input logic neg);
    logic [PROD_W-1:0] t;
    logic [15:0]       r;
    t = (p + (PROD_W'(1) << 45)) >> 46;
    r = (t > PROD_W'(32767)) ? 16'd32767 : t[15:0];
    return neg ? (16'd0 - r) : r;
  endfunction

  assign in_xfer    = in_i.valid && in_i.ready;
  assign issue      = state_q == ST_SWEEP;
  assign pipe_empty = !a_vld_q && !c_vld_q && !d_vld_q && !e_vld_q;

  assign f_min     = (in_i.freq_hz < 24'd256) ? 24'd256 : in_i.freq_hz;
  assign step_prod = {32'd0, f_min} * {24'd0, phase_scale_q};

  // slot update, stage B
  assign b_slot_vld = valid_q[a_slot_q];
  assign b_match    = b_slot_vld && (rd_q.note == note_q) && (rd_q.instrument == ins_q);
  assign ph_new     = rd_q.phase + rd_q.step;
  assign lvl_up     = {1'b0, rd_q.level} + {1'b0, attack_q};

  always_comb begin
    if (rd_q.releasing) begin
      lvl_new = (rd_q.level > release_q) ? (rd_q.level - release_q) : 16'd0;
    end else begin
      lvl_new = (lvl_up < {1'b0, rd_q.target}) ? lvl_up[15:0] : rd_q.target;
    end
  end

  assign sfrac = ph_new[29 -: SINE_TABLE_BITS];
  assign sidx  = ph_new[30] ? (SIDX_W'(SINE_SIZE - 1) - {1'b0, sfrac}) : {1'b0, sfrac};
  assign ktmp  = {1'b0, rd_q.pan, {PAN_TABLE_BITS{1'b0}}} + KT_W'(32768);
  assign kr    = ktmp[KT_W-1 -: PIDX_W];
  assign kl    = PIDX_W'(PAN_SIZE - 1) - kr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = a_slot_q;
    mem_wdata = rd_q;
    b_free    = 1'b0;
    if (state_q == ST_ALLOC) begin
      if (hit_q) begin
        mem_we              = 1'b1;
        mem_waddr           = hit_idx_q;
        mem_wdata           = hit_word_q;
        mem_wdata.step      = step_q;
        mem_wdata.pan       = pan_q;
        mem_wdata.target    = vel_q;
        mem_wdata.releasing = 1'b0;
        if (retrig_q) begin
          mem_wdata.phase = 32'd0;
          mem_wdata.level = 16'd0;
        end
      end else if (free_q) begin
        mem_we    = 1'b1;
        mem_waddr = free_idx_q;
        mem_wdata = '{note: note_q, instrument: ins_q, phase: 32'd0, step: step_q,
                      level: 16'd0, target: vel_q, pan: pan_q, releasing: 1'b0};
      end
    end else if (a_vld_q && b_slot_vld) begin
      case (op_q)
        OP_TICK: begin
          mem_we          = 1'b1;
          mem_wdata.phase = ph_new;
          mem_wdata.level = lvl_new;
          b_free          = rd_q.releasing && (lvl_new == 16'd0);
        end
        OP_NOTE_OFF, OP_ALL_OFF: begin
          if (engine_q) begin
            if (op_q == OP_ALL_OFF || b_match) begin
              mem_we              = 1'b1;
              mem_wdata.releasing = 1'b1;
            end
          end else begin
            b_free = (op_q == OP_ALL_OFF) || b_match || (rd_q.level == 16'd0);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (issue) rd_q <= mem[sweep_q];
  end

  // datapath pipeline
  assign vmag = {16'd0, sine_q} * {15'd0, lvl_c_q};
  assign vs_d = sneg_q ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      a_vld_q <= issue;
      c_vld_q <= a_vld_q && (op_q == OP_TICK) && b_slot_vld;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_slot_q <= sweep_q;
    sine_q   <= SINE_ROM[sidx];
    gr_c_q   <= PAN_ROM[kr];
    gl_c_q   <= PAN_ROM[kl];
    sneg_q   <= ph_new[31];
    lvl_c_q  <= lvl_new;
    vs_q     <= vs_d;
    gr_q     <= gr_c_q;
    gl_q     <= gl_c_q;
    pr_q     <= vs_q * $signed({1'b0, gr_q});
    pl_q     <= vs_q * $signed({1'b0, gl_q});
  end

  assign mag_l     = acc_l_q[ACC_W-1] ? (ACC_W'(0) - acc_l_q) : acc_l_q;
  assign mag_r     = acc_r_q[ACC_W-1] ? (ACC_W'(0) - acc_r_q) : acc_r_q;
  assign div_start = (state_q == ST_DRAIN) && pipe_empty && (op_q == OP_TICK) &&
                     (n_q != '0);

  ptvm_div u_div_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_l),
    .divisor_i  (n_q),
    .done_o     (done_l),
    .quotient_o (quo_l)
  );

  ptvm_div u_div_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_r),
    .divisor_i  (n_q),
    .done_o     (done_r),
    .quotient_o (quo_r)
  );

  // control, voice bookkeeping and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_scale_q <= PHASE_SCALE_RST;
      attack_q      <= ATTACK_STEP_RST;
      release_q     <= RELEASE_STEP_RST;
      gain_q        <= OUTPUT_GAIN_RST;
      engine_q      <= 1'b1;
      valid_q       <= '0;
      cnt_q         <= '0;
      sweep_q       <= '0;
      hit_q         <= 1'b0;
      free_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_PHASE_SCALE:  phase_scale_q <= cfg_i.data;
          CFG_ATTACK_STEP:  attack_q      <= cfg_i.data[15:0];
          CFG_RELEASE_STEP: release_q     <= cfg_i.data[15:0];
          CFG_OUTPUT_GAIN:  gain_q        <= cfg_i.data[GAIN_W-1:0];
          CFG_ENGINE_RUN:   engine_q      <= cfg_i.data[0];
          default: ;
        endcase
      end

      if (out_valid_q && out_o.ready && state_q != ST_DONE) out_valid_q <= 1'b0;

      // free a slot from the sweep, or take one at allocation
      if (b_free) begin
        valid_q[a_slot_q] <= 1'b0;
        cnt_q             <= cnt_q - VCNT_W'(1);
      end else if (state_q == ST_ALLOC && !hit_q && free_q) begin
        valid_q[free_idx_q] <= 1'b1;
        cnt_q               <= cnt_q + VCNT_W'(1);
      end

      if (a_vld_q && op_q == OP_NOTE_ON) begin
        if (b_match && !hit_q) begin
          hit_q      <= 1'b1;
          hit_idx_q  <= a_slot_q;
          hit_word_q <= rd_q;
        end
        if (!b_slot_vld && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= a_slot_q;
        end
      end

      if (e_vld_q) begin
        acc_l_q <= acc_l_q + ACC_W'(pl_q);
        acc_r_q <= acc_r_q + ACC_W'(pr_q);
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            op_q     <= op_e'(in_i.op);
            note_q   <= in_i.note;
            ins_q    <= in_i.instrument;
            vel_q    <= in_i.velocity;
            retrig_q <= in_i.retrigger;
            pan_q    <= in_i.pan;
            step_q   <= step_prod[39:8];
            n_q      <= cnt_q;
            acc_l_q  <= '0;
            acc_r_q  <= '0;
            hit_q    <= 1'b0;
            free_q   <= 1'b0;
            sweep_q  <= '0;
            res_l_q  <= 16'd0;
            res_r_q  <= 16'd0;
            stat_q   <= STAT_OK;
            if (op_e'(in_i.op) == OP_NOTE_ON &&
                (in_i.freq_hz == 24'd0 || in_i.velocity == 16'd0)) begin
              stat_q  <= STAT_IGNORED;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (sweep_q == SLOT_W'(MAX_VOICES - 1)) state_q <= ST_DRAIN;
          else sweep_q <= sweep_q + SLOT_W'(1);
        end
        ST_DRAIN: begin
          if (pipe_empty) begin
            case (op_q)
              OP_TICK: begin
                negl_q  <= acc_l_q[ACC_W-1];
                negr_q  <= acc_r_q[ACC_W-1];
                state_q <= (n_q == '0) ? ST_DONE : ST_DIV;
              end
              OP_NOTE_ON: state_q <= ST_ALLOC;
              default:    state_q <= ST_DONE;
            endcase
          end
        end
        ST_ALLOC: begin
          if (!hit_q && !free_q) stat_q <= STAT_FULL;
          state_q <= ST_DONE;
        end
        ST_DIV: begin
          if (done_l && done_r) state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_l_q <= PROD_W'(quo_l) * PROD_W'(gain_q);
          prod_r_q <= PROD_W'(quo_r) * PROD_W'(gain_q);
          state_q  <= ST_RND;
        end
        ST_RND: begin
          res_l_q <= round_sat(prod_l_q, negl_q);
          res_r_q <= round_sat(prod_r_q, negr_q);
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_l_q     <= res_l_q;
            out_r_q     <= res_r_q;
            out_stat_q  <= stat_q;
            out_cnt_q   <= (32'(cnt_q) > 32'd31) ? 5'd31 : 5'(cnt_q);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cfg_i.ready         = 1'b1;
  assign in_i.ready          = state_q == ST_IDLE;
  assign out_o.valid         = out_valid_q;
  assign out_o.left_sample   = $signed(out_l_q);
  assign out_o.right_sample  = $signed(out_r_q);
  assign out_o.active_voices = out_cnt_q;
  assign out_o.status        = out_stat_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (32'(cnt_q) == $countones(valid_q)))
    else $error("voice count out of step with valid slots");

  a_pipe_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(a_vld_q || c_vld_q || d_vld_q || e_vld_q))
    else $error("slot pipeline busy while idle");

  a_silent_non_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stat_q != STAT_OK) |-> (out_l_q == 16'd0 && out_r_q == 16'd0))
    else $error("samples on a result that is not a tick");

  a_div_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == ST_DIV))
    else $error("divider started outside a tick");

endmodule
